// ===== hdl/hptm_pkg.sv =====
package hptm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int EXPO_W   = 24;
  localparam int GAMMA_W  = 16;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PIX_W    = 8;
  localparam int UNIT_W   = 17;   // Q1.16 values in 0..1.0
  localparam int ND_W     = 20;   // curve numerator and denominator
  localparam int Q_W      = 18;   // saturated quotient
  localparam int U1_W     = 33;   // exponent argument of the pre-curve
  localparam int U2_W     = 25;   // exponent argument of the gamma step
  localparam int LANE_LAT = 35;
  localparam int NUM_LANES = 3;

  localparam logic [UNIT_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [16:0]       LOG2E_Q16 = 17'd94548;
  localparam logic [16:0]       WHITE_SCALE = 17'd90378;
  localparam logic [Q_W-1:0]    FILMIC_EF = 18'd4369;
  localparam logic [UNIT_W-1:0] HEJL_BIAS = 17'd262;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_GAMMA     = 2'd2;

  localparam logic [EXPO_W-1:0]  EXPOSURE_RESET = 24'd65536;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET    = 16'd1862;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACES     = 2'd0,
    MODE_FILMIC   = 2'd1,
    MODE_HEJL     = 2'd2,
    MODE_REINHARD = 2'd3
  } curve_mode_t;

  typedef struct packed {
    curve_mode_t          mode;
    logic [EXPO_W-1:0]    exposure_gain;
    logic [GAMMA_W-1:0]   inv_gamma;
  } hptm_cfg_t;

  // 2^(-k/16) in Q1.16.
  function automatic logic [UNIT_W-1:0] pow2_neg_tab(input logic [4:0] k);
    logic [UNIT_W-1:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  // log2(1 + k/16) in Q16.
  function automatic logic [UNIT_W-1:0] log2_tab(input logic [4:0] k);
    logic [UNIT_W-1:0] v;
    case (k)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/hptm_exp2.sv =====
module hptm_exp2 import hptm_pkg::*; #(
  parameter int UW = U1_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [UW-1:0]     u,
  output logic [UNIT_W-1:0] v
);

  // Two stages: table lookup with the interpolation product, then the shift.
  logic              zero_r;
  logic [4:0]        n_r;
  logic [UNIT_W-1:0] base_r;
  logic [23:0]       prod_r;
  logic [UNIT_W-1:0] v_r;

  logic [4:0]        k;
  logic [UNIT_W-1:0] base;
  logic [11:0]       diff;
  logic [UNIT_W-1:0] interp;

  always_comb begin
    k      = {1'b0, u[15:12]};
    base   = pow2_neg_tab(k);
    diff   = 12'(base - pow2_neg_tab(5'(k + 5'd1)));
    interp = base_r - UNIT_W'(prod_r[23:12]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= (u[UW-1:16] > (UW-16)'(16));
      n_r    <= u[20:16];
      base_r <= base;
      prod_r <= 24'(diff) * 24'(u[11:0]);
      v_r    <= zero_r ? '0 : (interp >> n_r);
    end
  end

  assign v = v_r;

endmodule

// ===== hdl/hptm_div.sv =====
module hptm_div import hptm_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [ND_W-1:0] num,
  input  logic [ND_W-1:0] den,
  output logic [Q_W-1:0]  quo
);

  // Restoring division of num * 2^16 by den, one quotient bit per stage.
  // Quotients of 2^18 and above saturate; every curve clamps them anyway.
  localparam int RW = ND_W + 16;

  logic [RW-1:0]   rem_r [0:Q_W];
  logic [Q_W-1:0]  q_r   [0:Q_W];
  logic [ND_W-1:0] den_r [0:Q_W];
  logic            ovf_r [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {num, 16'd0};
      q_r[0]   <= '0;
      den_r[0] <= den;
      ovf_r[0] <= ({2'b00, num} >= {den, 2'b00});
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_stage
    localparam int BIT = Q_W - j;
    logic [RW+Q_W-1:0] dsh;
    logic              ge;

    always_comb begin
      dsh = (RW+Q_W)'(den_r[j-1]) << BIT;
      ge  = ((RW+Q_W)'(rem_r[j-1]) >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? RW'((RW+Q_W)'(rem_r[j-1]) - dsh) : rem_r[j-1];
        q_r[j]   <= q_r[j-1] | (ge ? (Q_W'(1) << BIT) : '0);
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign quo = ovf_r[Q_W] ? '1 : q_r[Q_W];

endmodule

// ===== hdl/hptm_lane.sv =====
module hptm_lane import hptm_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  hptm_cfg_t           cfg,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [PIX_W-1:0]    pix
);

  // Exposure product and the log2(e) scaling.
  logic [31:0]   t_r;
  logic [U1_W-1:0] u_r;
  logic [UNIT_W-1:0] ex1;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= 32'((48'(sample) * 48'(cfg.exposure_gain)) >> 16);
      u_r <= U1_W'((49'(t_r) * 49'(LOG2E_Q16)) >> 16);
    end
  end

  hptm_exp2 #(.UW(U1_W)) u_exp_pre (.clk(clk), .en(en), .u(u_r), .v(ex1));

  // Curve base, inner polynomial term, then numerator and denominator.
  logic [UNIT_W-1:0] f;
  logic [17:0]       b_nxt, b_r, b2_r;
  logic [18:0]       cmn, cmd;
  logic [19:0]       can, cad, kn, kd;
  logic [ND_W-1:0]   an_r, ad_r, num_r, den_r;

  always_comb begin
    f = ONE_Q16 - ex1;
    case (cfg.mode)
      MODE_FILMIC: b_nxt = {f, 1'b0};
      MODE_HEJL:   b_nxt = (f > HEJL_BIAS) ? 18'(f - HEJL_BIAS) : '0;
      default:     b_nxt = 18'(f);
    endcase
    case (cfg.mode)
      MODE_ACES: begin
        cmn = 19'd164495; cmd = 19'd159252; can = 20'd1966;  cad = 20'd38666;
        kn  = 20'd0;      kd  = 20'd9175;
      end
      MODE_FILMIC: begin
        cmn = 19'd9830;   cmd = 19'd9830;   can = 20'd3277;  cad = 20'd32768;
        kn  = 20'd262;    kd  = 20'd3932;
      end
      MODE_HEJL: begin
        cmn = 19'd406323; cmd = 19'd406323; can = 20'd32768; cad = 20'd111411;
        kn  = 20'd0;      kd  = 20'd3932;
      end
      default: begin
        cmn = '0; cmd = '0; can = '0; cad = '0; kn = '0; kd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r  <= b_nxt;
      b2_r <= b_r;
      an_r <= ND_W'(((37'(b_r) * 37'(cmn)) >> 16) + 37'(can));
      ad_r <= ND_W'(((37'(b_r) * 37'(cmd)) >> 16) + 37'(cad));
      if (cfg.mode == MODE_REINHARD) begin
        num_r <= ND_W'(b2_r);
        den_r <= ND_W'(b2_r) + ND_W'(ONE_Q16);
      end else begin
        num_r <= ND_W'(((38'(b2_r) * 38'(an_r)) >> 16) + 38'(kn));
        den_r <= ND_W'(((38'(b2_r) * 38'(ad_r)) >> 16) + 38'(kd));
      end
    end
  end

  logic [Q_W-1:0] quo;

  hptm_div u_div (.clk(clk), .en(en), .num(num_r), .den(den_r), .quo(quo));

  // Filmic offset and white scale, then clamp to one.
  logic [Q_W-1:0]    mm, q8_r;
  logic [34:0]       ws_r;
  logic [UNIT_W-1:0] m_nxt, m_r;

  always_comb begin
    mm = (quo > FILMIC_EF) ? (quo - FILMIC_EF) : '0;
    if (cfg.mode == MODE_FILMIC) begin
      m_nxt = (ws_r[34:16] > 19'(ONE_Q16)) ? ONE_Q16 : UNIT_W'(ws_r[34:16]);
    end else begin
      m_nxt = (q8_r > Q_W'(ONE_Q16)) ? ONE_Q16 : UNIT_W'(q8_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q8_r <= quo;
      ws_r <= 35'(mm) * 35'(WHITE_SCALE);
      m_r  <= m_nxt;
    end
  end

  // Gamma: normalize, interpolate log2, scale by the exponent.
  logic [3:0]        lz;
  logic [15:0]       msh;
  logic              byp_nxt;
  logic [UNIT_W-1:0] bv_nxt;
  logic [3:0]        lz_r, lz2_r;
  logic [3:0]        k_r;
  logic [11:0]       r_r;
  logic [UNIT_W-1:0] lbase_r;
  logic [24:0]       lprod_r;
  logic [20:0]       neg_r;
  logic [U2_W-1:0]   e_r;
  logic [UNIT_W-1:0] lbase;
  logic [12:0]       ldiff;
  logic [UNIT_W-1:0] lf;
  logic              byp_r [0:5];
  logic [UNIT_W-1:0] bv_r  [0:5];

  always_comb begin
    lz = 4'd15;
    for (int i = 0; i < 16; i++) begin
      if (m_r[i]) lz = 4'(15 - i);
    end
    msh = m_r[15:0] << lz;
    if (cfg.mode == MODE_HEJL) begin
      byp_nxt = 1'b1; bv_nxt = m_r;
    end else if (cfg.inv_gamma == '0 || m_r[16]) begin
      byp_nxt = 1'b1; bv_nxt = ONE_Q16;
    end else if (m_r == '0) begin
      byp_nxt = 1'b1; bv_nxt = '0;
    end else begin
      byp_nxt = 1'b0; bv_nxt = '0;
    end
    lbase = log2_tab({1'b0, k_r});
    ldiff = 13'(log2_tab(5'({1'b0, k_r}) + 5'd1) - lbase);
    lf    = lbase_r + UNIT_W'(lprod_r[24:12]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lz_r    <= lz;
      k_r     <= msh[14:11];
      r_r     <= {msh[10:0], 1'b0};
      byp_r[0] <= byp_nxt;
      bv_r[0]  <= bv_nxt;
      lbase_r <= lbase;
      lprod_r <= 25'(ldiff) * 25'(r_r);
      lz2_r   <= lz_r;
      neg_r   <= (21'(lz2_r) + 21'd1) * 21'(ONE_Q16) - 21'(lf);
      e_r     <= U2_W'((37'(neg_r) * 37'(cfg.inv_gamma)) >> 12);
      for (int s = 1; s < 6; s++) begin
        byp_r[s] <= byp_r[s-1];
        bv_r[s]  <= bv_r[s-1];
      end
    end
  end

  logic [UNIT_W-1:0] ex2;
  logic [UNIT_W-1:0] fv;
  logic [PIX_W-1:0]  pix_r;

  hptm_exp2 #(.UW(U2_W)) u_exp_gamma (.clk(clk), .en(en), .u(e_r), .v(ex2));

  always_comb begin
    fv = byp_r[5] ? bv_r[5] : ex2;
    if (fv > ONE_Q16) fv = ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= PIX_W'((25'(fv) * 25'd255) >> 16);
    end
  end

  assign pix = pix_r;

endmodule

// ===== hdl/hdr_pixel_tone_mapper_unit.sv =====
// Throughput: one pixel word per clock while out_stall does not hold the
// pipeline; the three color lanes and the 19-stage divider inside each lane
// are fully pipelined.
// Reset (rst_n low, synchronous): curve_mode ACES, exposure gain 1.0,
// inverse gamma 1862 (Q4.12), and the pipeline is emptied.
module hdr_pixel_tone_mapper_unit import hptm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_red_in,
  input  logic [SAMPLE_W-1:0]   in_green_in,
  input  logic [SAMPLE_W-1:0]   in_blue_in,
  input  logic                  in_frame_end_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_red_out,
  output logic [PIX_W-1:0]      out_green_out,
  output logic [PIX_W-1:0]      out_blue_out,
  output logic                  out_frame_end_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. Writes to an index past the last register
  // are dropped.
  hptm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= MODE_ACES;
      cfg_r.exposure_gain <= EXPOSURE_RESET;
      cfg_r.inv_gamma     <= GAMMA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURVE_MODE:    cfg_r.mode          <= curve_mode_t'(cfg_data[MODE_W-1:0]);
        CFG_EXPOSURE_GAIN: cfg_r.exposure_gain <= cfg_data[EXPO_W-1:0];
        CFG_INV_GAMMA:     cfg_r.inv_gamma     <= cfg_data[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one. It advances unless the last stage
  // holds a word that the consumer is stalling; the final lane register
  // then acts as the output register and keeps its word stable.
  logic adv;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Valid and frame-end flags ride alongside the lanes.
  logic vld_r [0:LANE_LAT-1];
  logic fe_r  [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LANE_LAT; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < LANE_LAT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fe_r[0] <= in_frame_end_in;
      for (int s = 1; s < LANE_LAT; s++) fe_r[s] <= fe_r[s-1];
    end
  end

  // One lane per color channel, all running the same curve.
  logic [SAMPLE_W-1:0] lane_in  [0:NUM_LANES-1];
  logic [PIX_W-1:0]    lane_out [0:NUM_LANES-1];

  assign lane_in[0] = in_red_in;
  assign lane_in[1] = in_green_in;
  assign lane_in[2] = in_blue_in;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    hptm_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .cfg    (cfg_r),
      .sample (lane_in[l]),
      .pix    (lane_out[l])
    );
  end

  // Merge the three lanes with the flag into one result word.
  assign out_valid         = vld_r[LANE_LAT-1];
  assign out_red_out       = lane_out[0];
  assign out_green_out     = lane_out[1];
  assign out_blue_out      = lane_out[2];
  assign out_frame_end_out = fe_r[LANE_LAT-1];

endmodule
